// ===== hw/rtl/rwm_pkg.sv =====
// rwm_pkg: shared widths, status codes and the divider request type
// for the ring window mean block; no dependencies
package rwm_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int IDX_W     = 8;
  localparam int WIN_W     = 9;
  localparam int LEN_W     = 9;
  localparam int STATUS_W  = 2;
  // 511 samples of 32 bits fit a 41-bit signed sum
  localparam int SUM_W     = 41;
  localparam int DIV_CNT_W = 6;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_WINDOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd2;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [WIN_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== hw/rtl/ring_window_mean.sv =====
// ring_window_mean: top level, request sequencer, summing loop and result register
// depends on rwm_pkg, rwm_store and rwm_divider
//
// Usage:
//   Input requests arrive on in_t*. in_tuser selects the kind: 0 stores
//   in_tdata value at index into the sample ring, 1 asks for the mean of
//   window samples ending at index, walking backward and wrapping at the
//   table length set through cfg_wr_en / cfg_wr_data (256 after reset,
//   clipped to DEPTH).
//   A store request gives no result. A query gives one
//   result on out_t*: mean in out_tdata, status in out_tuser (0 ok, 1 bad
//   window, 2 index beyond length; mean is 0 on an error).
//   An error query goes straight to the output register; a good query first
//   sums its window through the ring memory's single read port, which
//   returns one sample per cycle, then the restoring divider produces one
//   quotient bit per cycle over a 41-bit sum.
//   One request is in work at a time; a new request is taken while a
//   finished result waits in the output register. If the receiver holds
//   out_tready low, a second query finishes its work and then waits, and
//   in_tready stays low until the output register frees.
//   Reset sets the table length to 256 and clears all control state; the
//   sample ring is not cleared and must be written before it is queried.
module ring_window_mean #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,    // index[7:0], value[39:8], window[48:40], zeros above
  input  logic        in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // mean[31:0]
  output logic [1:0]  out_tuser,   // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data  // table_length
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                         state_r;
  logic [rwm_pkg::LEN_W-1:0]          table_length_r;
  logic [AW-1:0]                      pos_r;
  logic [AW-1:0]                      len_m1_r;
  logic [rwm_pkg::WIN_W-1:0]          left_r;
  logic [rwm_pkg::WIN_W-1:0]          win_r;
  logic                               rd_valid_r;
  logic signed [rwm_pkg::SUM_W-1:0]   sum_r;
  logic [rwm_pkg::SAMPLE_W-1:0]       res_mean_r;
  logic [rwm_pkg::STATUS_W-1:0]       res_status_r;
  logic                               out_valid_r;
  logic [rwm_pkg::SAMPLE_W-1:0]       out_mean_r;
  logic [rwm_pkg::STATUS_W-1:0]       out_status_r;

  logic                               in_fire;
  logic                               out_fire;
  logic                               mode;
  logic [rwm_pkg::IDX_W-1:0]          idx;
  logic [rwm_pkg::SAMPLE_W-1:0]       value;
  logic [rwm_pkg::WIN_W-1:0]          window;
  logic [rwm_pkg::LEN_W-1:0]          len_eff;
  logic [rwm_pkg::LEN_W-1:0]          len_m1;
  logic [AW+rwm_pkg::IDX_W-1:0]       idx_wide;
  logic [AW+rwm_pkg::LEN_W-1:0]       len_m1_wide;
  logic [AW-1:0]                      idx_addr;
  logic                               bad_window;
  logic                               bad_index;
  logic                               wr_en;
  logic                               rd_en;
  logic [AW-1:0]                      pos_nxt;
  logic [rwm_pkg::SAMPLE_W-1:0]       rd_data;
  logic signed [rwm_pkg::SUM_W-1:0]   sum_nxt;
  logic [rwm_pkg::SUM_W-1:0]          sum_mag;
  logic                               sum_done;
  logic                               fin_load;
  rwm_pkg::div_req_t                  div_req;
  logic                               div_done;
  logic [rwm_pkg::SAMPLE_W-1:0]       div_quo;

  assign mode   = in_tuser;
  assign idx    = in_tdata[7:0];
  assign value  = in_tdata[39:8];
  assign window = in_tdata[48:40];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // effective ring length is the register clipped to the store depth
  assign len_eff     = (int'(table_length_r) > DEPTH) ? rwm_pkg::LEN_W'(DEPTH)
                                                      : table_length_r;
  assign len_m1      = len_eff - 1'b1;
  assign idx_wide    = {{AW{1'b0}}, idx};
  assign len_m1_wide = {{AW{1'b0}}, len_m1};
  assign idx_addr    = idx_wide[AW-1:0];

  assign bad_window = (window == '0) || (window > len_eff);
  assign bad_index  = ({1'b0, idx} >= len_eff);

  assign wr_en = in_fire && !mode && (int'(idx) < DEPTH);

  // summing loop: one read issued per cycle, its data added in the following cycle
  assign rd_en    = (state_r == S_SUM) && (left_r != '0);
  assign pos_nxt  = (pos_r == '0) ? len_m1_r : pos_r - 1'b1;
  assign sum_nxt  = sum_r + rwm_pkg::SUM_W'(signed'(rd_data));
  assign sum_done = (state_r == S_SUM) && (left_r == '0) && !rd_valid_r;
  assign sum_mag  = sum_r[rwm_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  assign div_req.start   = sum_done;
  assign div_req.neg     = sum_r[rwm_pkg::SUM_W-1];
  assign div_req.divisor = win_r;

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  rwm_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  rwm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= rwm_pkg::LEN_W'(256);
    end else if (cfg_wr_en) begin
      table_length_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && mode) begin
            state_r <= (bad_window || bad_index) ? S_FIN : S_SUM;
          end
        end
        S_SUM: begin
          if (sum_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && mode) begin
      pos_r    <= idx_addr;
      len_m1_r <= len_m1_wide[AW-1:0];
      left_r   <= window;
      win_r    <= window;
      sum_r    <= '0;
      priority if (bad_window) begin
        res_mean_r   <= '0;
        res_status_r <= rwm_pkg::ST_BAD_WINDOW;
      end else if (bad_index) begin
        res_mean_r   <= '0;
        res_status_r <= rwm_pkg::ST_BAD_INDEX;
      end else begin
        res_mean_r   <= '0;
        res_status_r <= rwm_pkg::ST_OK;
      end
    end else begin
      if (rd_en) begin
        pos_r  <= pos_nxt;
        left_r <= left_r - 1'b1;
      end
      if (rd_valid_r) begin
        sum_r <= sum_nxt;
      end
      if (div_done) begin
        res_mean_r <= div_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_mean_r   <= res_mean_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mean_r;
  assign out_tuser  = out_status_r;

  a_err_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != rwm_pkg::ST_OK) |-> (out_tdata == '0))
    else $error("error result carries a nonzero mean");

  a_read_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> (state_r == S_SUM))
    else $error("sample read returned outside the summing loop");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode |=> (state_r != S_IDLE))
    else $error("accepted query did not start work");

endmodule

// ===== hw/rtl/rwm_store.sv =====
// rwm_store: sample ring memory, one write and one registered read port
// depends on rwm_pkg for the sample width
module rwm_store #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rwm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [rwm_pkg::SAMPLE_W-1:0] rd_data
);

  logic [rwm_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/rwm_divider.sv =====
// rwm_divider: restoring divider, one quotient bit per cycle, sign fixed at end
// depends on rwm_pkg for widths and the request struct
module rwm_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rwm_pkg::div_req_t            req,
  input  logic [rwm_pkg::SUM_W-1:0]    dividend,
  output logic                         done,
  output logic [rwm_pkg::SAMPLE_W-1:0] quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [rwm_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           neg_r;
  logic [rwm_pkg::WIN_W-1:0]      div_r;
  logic [rwm_pkg::WIN_W-1:0]      rem_r;
  logic [rwm_pkg::SUM_W-1:0]      quo_r;

  logic [rwm_pkg::WIN_W:0]        trial;
  logic [rwm_pkg::WIN_W:0]        diff;
  logic                           q_bit;
  logic [rwm_pkg::WIN_W-1:0]      rem_nxt;
  logic [rwm_pkg::SUM_W-1:0]      q_signed;

  always_comb begin
    trial   = {rem_r, quo_r[rwm_pkg::SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    q_bit   = (trial >= {1'b0, div_r});
    rem_nxt = q_bit ? diff[rwm_pkg::WIN_W-1:0] : trial[rwm_pkg::WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == rwm_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= rwm_pkg::DIV_CNT_W'(rwm_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rwm_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.neg;
      div_r <= req.divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[rwm_pkg::SUM_W-2:0], q_bit};
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = q_signed[rwm_pkg::SAMPLE_W-1:0];
  assign done     = done_r;

endmodule
